>>> rtl/core/ble_pkg.sv
// ----------------------------------------------------------------------------
// ble_pkg
// shared constants for the bounded list engine
// ----------------------------------------------------------------------------
package ble_pkg;
   localparam int CAPACITY_DEF = 64;
   localparam int OPC_W = 4;
   localparam int DATA_W = 32;
   localparam int POS_W = 7;
   localparam int STAT_W = 2;

   localparam logic [OPC_W-1:0] OP_INS_HEAD = 4'd0;
   localparam logic [OPC_W-1:0] OP_INS_TAIL = 4'd1;
   localparam logic [OPC_W-1:0] OP_DEL_HEAD = 4'd2;
   localparam logic [OPC_W-1:0] OP_DEL_TAIL = 4'd3;
   localparam logic [OPC_W-1:0] OP_INS_POS  = 4'd4;
   localparam logic [OPC_W-1:0] OP_DEL_POS  = 4'd5;
   localparam logic [OPC_W-1:0] OP_DUMP     = 4'd6;
   localparam logic [OPC_W-1:0] OP_REVERSE  = 4'd7;
   localparam logic [OPC_W-1:0] OP_DEDUP    = 4'd8;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;
endpackage

>>> rtl/core/bounded_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_list_engine
// ordered list of signed words in one memory, walked by a small sequencer
// ----------------------------------------------------------------------------
// error and trivial ops respond without a memory walk; shifts move one element
// at a time; dump gives one response per element; reverse and dedup walk the list
// throughput: one transaction at a time, taken only while the sequencer is idle
// reset: list length cleared, sequencer idle; memory contents undefined
module bounded_list_engine #(
   parameter int CAPACITY = ble_pkg::CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ble_pkg::OPC_W-1:0]   req_opcode,
   input  logic signed [ble_pkg::DATA_W-1:0] req_value,
   input  logic [ble_pkg::POS_W-1:0]   req_position,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ble_pkg::STAT_W-1:0]  rsp_status,
   output logic signed [ble_pkg::DATA_W-1:0] rsp_element,
   output logic [ble_pkg::POS_W-1:0]   rsp_length,
   output logic                        rsp_last
);
   import ble_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW = $clog2(CAPACITY + 1);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SHR   = 4'd2;  // shift right, read phase
   localparam logic [3:0] S_SHRW  = 4'd3;  // shift right, write phase
   localparam logic [3:0] S_SHL   = 4'd4;
   localparam logic [3:0] S_SHLW  = 4'd5;
   localparam logic [3:0] S_DMPR  = 4'd6;
   localparam logic [3:0] S_DMPO  = 4'd7;
   localparam logic [3:0] S_REVA  = 4'd8;
   localparam logic [3:0] S_REVB  = 4'd9;
   localparam logic [3:0] S_REVW  = 4'd10;
   localparam logic [3:0] S_DDI   = 4'd11; // read element i
   localparam logic [3:0] S_DDJ   = 4'd12; // read element j, compare
   localparam logic [3:0] S_DDC   = 4'd13;
   localparam logic [3:0] S_RSP   = 4'd14;

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_ff;
   logic [AW-1:0]     raddr;
   logic              we;
   logic [AW-1:0]     waddr;
   logic [DATA_W-1:0] wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   logic [3:0]        state_ff, state_in;
   logic [LW-1:0]     len_ff, len_in;
   logic [OPC_W-1:0]  op_ff, op_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [LW-1:0]     i_ff, i_in, j_ff, j_in, w_ff, w_in, tgt_ff, tgt_in;
   logic [DATA_W-1:0] tmp_ff, tmp_in;
   logic [STAT_W-1:0] st_ff, st_in;
   logic [DATA_W-1:0] el_ff, el_in;
   logic              lst_ff, lst_in;
   logic              seen_ff, seen_in;

   wire [POS_W:0] pos_w = {1'b0, req_position};
   wire [POS_W:0] len_w = {1'b0, POS_W'(len_ff)};

   always_comb begin
      state_in = state_ff; len_in = len_ff; op_in = op_ff; val_in = val_ff;
      i_in = i_ff; j_in = j_ff; w_in = w_ff; tgt_in = tgt_ff; tmp_in = tmp_ff;
      st_in = st_ff; el_in = el_ff; lst_in = lst_ff; seen_in = seen_ff;
      raddr = AW'(i_ff); we = 1'b0; waddr = AW'(i_ff); wdata = rd_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_opcode; val_in = req_value;
               st_in = ST_OK; el_in = '0; lst_in = 1'b1;
               state_in = S_RSP;
               unique case (req_opcode)
                  OP_INS_HEAD, OP_INS_TAIL: begin
                     if (len_ff >= LW'(CAPACITY)) st_in = ST_FULL;
                     else begin
                        tgt_in = (req_opcode == OP_INS_HEAD) ? '0 : len_ff;
                        i_in = len_ff; state_in = S_SHR;
                     end
                  end
                  OP_DEL_HEAD: begin
                     if (len_ff == '0) st_in = ST_EMPTY;
                     else begin i_in = '0; state_in = S_SHL; end
                  end
                  OP_DEL_TAIL: begin
                     if (len_ff == '0) st_in = ST_EMPTY;
                     else len_in = len_ff - 1'b1;
                  end
                  OP_INS_POS: begin
                     if (len_ff == '0) st_in = ST_EMPTY;
                     else if (pos_w < 2 || pos_w > len_w) st_in = ST_BADPOS;
                     else if (len_ff >= LW'(CAPACITY)) st_in = ST_FULL;
                     else begin
                        tgt_in = LW'(req_position - 1'b1);
                        i_in = len_ff; state_in = S_SHR;
                     end
                  end
                  OP_DEL_POS: begin
                     if (len_ff == '0) st_in = ST_EMPTY;
                     else if (pos_w < 2 || pos_w + 1 > len_w) st_in = ST_BADPOS;
                     else begin i_in = LW'(req_position); state_in = S_SHL; end
                  end
                  OP_DUMP: begin
                     if (len_ff == '0) st_in = ST_EMPTY;
                     else begin i_in = '0; state_in = S_DMPR; end
                  end
                  OP_REVERSE: begin
                     if (len_ff > 1) begin
                        i_in = '0; j_in = len_ff - 1'b1; state_in = S_REVA;
                     end
                  end
                  OP_DEDUP: begin
                     i_in = '0; w_in = '0; state_in = S_DDI;
                  end
                  default: ;
               endcase
            end
         end
         // open a gap: move i-1 to i until i == tgt, then write value
         S_SHR: begin
            if (i_ff == tgt_ff) begin
               we = 1'b1; waddr = AW'(tgt_ff); wdata = val_ff;
               len_in = len_ff + 1'b1; state_in = S_RSP;
            end else begin
               raddr = AW'(i_ff - 1'b1); state_in = S_SHRW;
            end
         end
         S_SHRW: begin
            we = 1'b1; waddr = AW'(i_ff); i_in = i_ff - 1'b1; state_in = S_SHR;
         end
         // close a gap: move i+1 to i while i+1 < len
         S_SHL: begin
            if (i_ff + 1'b1 >= len_ff) begin
               len_in = len_ff - 1'b1; state_in = S_RSP;
            end else begin
               raddr = AW'(i_ff + 1'b1); state_in = S_SHLW;
            end
         end
         S_SHLW: begin
            we = 1'b1; waddr = AW'(i_ff); i_in = i_ff + 1'b1; state_in = S_SHL;
         end
         S_DMPR: begin
            raddr = AW'(i_ff); state_in = S_DMPO;
         end
         S_DMPO: begin
            el_in = rd_ff; lst_in = (i_ff + 1'b1 == len_ff); state_in = S_RSP;
         end
         S_REVA: begin
            if (i_ff >= j_ff) state_in = S_RSP;
            else begin raddr = AW'(i_ff); state_in = S_REVB; end
         end
         S_REVB: begin
            tmp_in = rd_ff; raddr = AW'(j_ff); state_in = S_REVW;
         end
         S_REVW: begin
            // element i takes j in this cycle; j takes the saved i next
            we = 1'b1; waddr = AW'(i_ff); wdata = rd_ff;
            state_in = S_DDC; // reuse: write tmp at j
         end
         S_DDI: begin
            if (i_ff >= len_ff) begin
               len_in = w_ff; state_in = S_RSP;
            end else begin
               raddr = AW'(i_ff); j_in = '0; seen_in = 1'b0; state_in = S_DDJ;
            end
         end
         S_DDJ: begin
            if (op_ff == OP_REVERSE) begin
               state_in = S_REVA;
            end else begin
               if (j_ff == '0) tmp_in = rd_ff;
               else if (rd_ff == tmp_ff) seen_in = 1'b1;
               if (j_ff == w_ff || (j_ff != '0 && rd_ff == tmp_ff)) begin
                  state_in = S_DDC;
               end else begin
                  raddr = AW'(j_ff); j_in = j_ff + 1'b1;
               end
            end
         end
         S_DDC: begin
            if (op_ff == OP_REVERSE) begin
               we = 1'b1; waddr = AW'(j_ff); wdata = tmp_ff;
               i_in = i_ff + 1'b1; j_in = j_ff - 1'b1; state_in = S_REVA;
            end else begin
               if (!seen_ff) begin
                  we = 1'b1; waddr = AW'(w_ff); wdata = tmp_ff;
                  w_in = w_ff + 1'b1;
               end
               i_in = i_ff + 1'b1; state_in = S_DDI;
            end
         end
         S_RSP: begin
            if (rsp_ready) begin
               if (op_ff == OP_DUMP && st_ff == ST_OK && !lst_ff) begin
                  i_in = i_ff + 1'b1; state_in = S_DMPR;
               end else state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; len_ff <= '0;
      end else begin
         state_ff <= state_in; len_ff <= len_in;
      end
      op_ff <= op_in; val_ff <= val_in; i_ff <= i_in; j_ff <= j_in; w_ff <= w_in;
      tgt_ff <= tgt_in; tmp_ff <= tmp_in; st_ff <= st_in; el_ff <= el_in;
      lst_ff <= lst_in; seen_ff <= seen_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = (state_ff == S_RSP);
   assign rsp_status  = st_ff;
   assign rsp_element = el_ff;
   assign rsp_length  = POS_W'(len_ff);
   assign rsp_last    = lst_ff;
endmodule

>>> rtl/core/ble_checker.sv
// ----------------------------------------------------------------------------
// ble_checker
// port-level checks for the bounded list engine
// ----------------------------------------------------------------------------
module ble_checker #(
   parameter int CAPACITY = ble_pkg::CAPACITY_DEF
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [31:0] rsp_element,
   input logic [6:0] rsp_length,
   input logic       rsp_last
);
   import ble_pkg::*;

   // no new transaction while a result is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   // error results carry zero element and last
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last && rsp_element == '0)
      else $error("bad error result");
   // length never exceeds capacity
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_length <= 7'(CAPACITY)) else $error("length overflow");
   // held result stays valid with a stable element
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element))
      else $error("result dropped");
endmodule

bind bounded_list_engine ble_checker #(.CAPACITY(CAPACITY)) u_ble_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_element(rsp_element), .rsp_length(rsp_length), .rsp_last(rsp_last)
);

>>> tb/bounded_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_checker
// watches the request and response channels of the bounded list engine,
// keeps its own copy of the list, and compares every response transaction
// field by field against the oldest predicted one
// ----------------------------------------------------------------------------
module bounded_list_checker #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [ble_pkg::OPC_W-1:0]           req_opcode,
   input  logic signed [ble_pkg::DATA_W-1:0]   req_value,
   input  logic [ble_pkg::POS_W-1:0]           req_position,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [ble_pkg::STAT_W-1:0]          rsp_status,
   input  logic signed [ble_pkg::DATA_W-1:0]   rsp_element,
   input  logic [ble_pkg::POS_W-1:0]           rsp_length,
   input  logic                                rsp_last,
   output int                                  mismatch_count,
   output int                                  pending_rsp,
   output int                                  list_size
);
   import ble_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] element;
      logic [POS_W-1:0]         length;
      logic                     last;
   } rsp_type;

   logic signed [DATA_W-1:0] shadow_list [$];
   rsp_type                  rsp_queue [$];

   assign pending_rsp = rsp_queue.size();
   assign list_size   = shadow_list.size();

   function automatic rsp_type mk_rsp(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] el,
                                      logic l);
      rsp_type r;
      r.status  = st;
      r.element = el;
      r.length  = POS_W'(shadow_list.size());
      r.last    = l;
      return r;
   endfunction

   // apply one request to the shadow list and queue its responses
   task automatic apply_op(logic [OPC_W-1:0] op, logic signed [DATA_W-1:0] val,
                           logic [POS_W-1:0] pos);
      logic [STAT_W-1:0]        st;
      int                       n;
      logic signed [DATA_W-1:0] kept [$];
      st = ST_OK;
      n  = shadow_list.size();
      case (op)
         OP_INS_HEAD, OP_INS_TAIL: begin
            if (n >= CAPACITY) st = ST_FULL;
            else if (op == OP_INS_HEAD) shadow_list.push_front(val);
            else shadow_list.push_back(val);
         end
         OP_DEL_HEAD, OP_DEL_TAIL: begin
            if (n == 0) st = ST_EMPTY;
            else if (op == OP_DEL_HEAD) void'(shadow_list.pop_front());
            else void'(shadow_list.pop_back());
         end
         OP_INS_POS: begin
            if (n == 0) st = ST_EMPTY;
            else if (pos < 2 || pos > n) st = ST_BADPOS;
            else if (n >= CAPACITY) st = ST_FULL;
            else shadow_list.insert(pos - 1, val);
         end
         OP_DEL_POS: begin
            // removes the element after position p
            if (n == 0) st = ST_EMPTY;
            else if (pos < 2 || pos + 1 > n) st = ST_BADPOS;
            else shadow_list.delete(pos);
         end
         OP_DUMP: begin
            if (n == 0) st = ST_EMPTY;
            else begin
               for (int i = 0; i < n; i++)
                  rsp_queue.push_back(mk_rsp(ST_OK, shadow_list[i], i == n - 1));
               return;
            end
         end
         OP_REVERSE: shadow_list.reverse();
         OP_DEDUP: begin
            foreach (shadow_list[i]) begin
               int hits [$];
               hits = kept.find_index() with (item == shadow_list[i]);
               if (hits.size() == 0) kept.push_back(shadow_list[i]);
            end
            shadow_list = kept;
         end
         default: ;
      endcase
      rsp_queue.push_back(mk_rsp(st, '0, 1'b1));
   endtask

   initial mismatch_count = 0;

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_element, rsp_length, rsp_last};
            if (rsp_queue.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected response: status %0d element %0d length %0d last %0b",
                           got.status, got.element, got.length, got.last);
            end else begin
               want = rsp_queue.pop_front();
               if (got !== want) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10) begin
                     $display("mismatch at %0t: exp st %0d el %0d len %0d last %0b",
                              $realtime, want.status, want.element, want.length,
                              want.last);
                     $display("   got st %0d el %0d len %0d last %0b",
                              got.status, got.element, got.length, got.last);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            apply_op(req_opcode, req_value, req_position);
      end
   end
endmodule

>>> tb/bounded_list_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_engine_test
// drives directed and random list operations into the bounded list engine
// with random gaps on both channels; a checker module predicts responses
// ----------------------------------------------------------------------------
module bounded_list_engine_test;
   import ble_pkg::*;

   localparam int CAP       = 64;
   localparam int WDOG_MAX  = 40000;   // watchdog limit, sized for a dedup of a full list
   localparam int N_RANDOM  = 180;
   localparam logic [OPC_W-1:0] OP_UNUSED_MAX = 4'd15;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [OPC_W-1:0]          req_opcode;
   logic signed [DATA_W-1:0]  req_value;
   logic [POS_W-1:0]          req_position;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [STAT_W-1:0]         rsp_status;
   logic signed [DATA_W-1:0]  rsp_element;
   logic [POS_W-1:0]          rsp_length;
   logic                      rsp_last;
   int                        mismatch_count;
   int                        pending_rsp;
   int                        list_size;
   int                        idle_cycles;
   bit                        hold_rsp;   // long receiver stall

   bounded_list_engine #(.CAPACITY(CAP)) dut (.*);

   bounded_list_checker #(.CAPACITY(CAP)) chk (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: counts cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("watchdog expired");
         $display("** bounded_list_engine: FAILED **");
         $finish;
      end
   end

   // response side: random stalls per transaction, plus the long hold-off
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (gap != 0 || hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            while (hold_rsp) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock iff rsp_valid);
      end
   end

   // one request transaction; gap drawn first, valid held until accepted
   task automatic send(logic [OPC_W-1:0] op, logic signed [DATA_W-1:0] val,
                       logic [POS_W-1:0] pos, bit no_gap = 1'b0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 9);
      if (!no_gap && $urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_value    <= val;
      req_position <= pos;
      @(posedge clock iff req_ready);
   endtask

   // stop offering and wait until every predicted response is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp != 0) @(posedge clock);
   endtask

   // random request biased toward legal positions and occasional duplicates
   task automatic send_random();
      logic [OPC_W-1:0]         op;
      logic signed [DATA_W-1:0] val;
      logic [POS_W-1:0]         pos;
      int                       r;
      r = $urandom_range(0, 99);
      if (r < 22) op = OP_INS_HEAD;
      else if (r < 44) op = OP_INS_TAIL;
      else if (r < 52) op = OP_DEL_HEAD;
      else if (r < 60) op = OP_DEL_TAIL;
      else if (r < 72) op = OP_INS_POS;
      else if (r < 80) op = OP_DEL_POS;
      else if (r < 88) op = OP_DUMP;
      else if (r < 93) op = OP_REVERSE;
      else if (r < 97) op = OP_DEDUP;
      else op = OPC_W'($urandom_range(OP_DEDUP + 1, OP_UNUSED_MAX));
      // small value pool makes dedup meaningful
      val = ($urandom_range(0, 1) == 0) ? DATA_W'($urandom_range(0, 7)) : $urandom;
      if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom);
      else pos = POS_W'($urandom_range(2, (list_size > 2) ? list_size : 2));
      send(op, val, pos);
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_opcode   = OP_INS_HEAD;
      req_value    = '0;
      req_position = '0;
      hold_rsp     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-list cases
      send(OP_DUMP, 0, 0);
      send(OP_DEL_HEAD, 0, 0);
      send(OP_DEL_TAIL, 0, 0);
      send(OP_INS_POS, 5, 2);
      send(OP_DEL_POS, 0, 2);
      send(OP_REVERSE, 0, 0);
      send(OP_DEDUP, 0, 0);
      send(OP_UNUSED_MAX, 0, 0);
      // extremes of value, positions at bounds
      send(OP_INS_HEAD, 32'sh7fffffff, 0);
      send(OP_INS_TAIL, 32'sh80000000, 7'h7f);
      send(OP_INS_POS, 32'hffffffff, 2);
      send(OP_INS_POS, 1, 1);
      send(OP_INS_POS, 1, 4);
      send(OP_INS_TAIL, 32'hffffffff, 0);
      send(OP_DEL_POS, 0, 3);
      send(OP_DEL_POS, 0, 1);
      send(OP_DEL_POS, 0, 2);
      send(OP_DUMP, 0, 0);
      send(OP_REVERSE, 0, 0);
      send(OP_DEDUP, 0, 0);
      send(OP_DUMP, 0, 0);
      // single element reverse
      send(OP_DEL_TAIL, 0, 0);
      send(OP_REVERSE, 0, 0);

      // fill to capacity with the receiver held off, then hit the full cases
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      while (list_size < CAP) send(OP_INS_TAIL, DATA_W'($urandom_range(0, 20)), 0, 1'b1);
      send(OP_INS_HEAD, 1, 0);
      send(OP_INS_TAIL, 1, 0);
      send(OP_INS_POS, 1, 10);
      send(OP_INS_POS, 1, 7'd64);
      send(OP_DUMP, 0, 0);
      send(OP_REVERSE, 0, 0);
      send(OP_DEDUP, 0, 0);
      // sender pause until all responses are back
      drain();

      for (int i = 0; i < N_RANDOM; i++) begin
         send_random();
         if (i == N_RANDOM / 2) drain();
      end

      drain();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp == 0) begin
         $display("** bounded_list_engine: PASSED **");
      end else begin
         $display("** bounded_list_engine: FAILED **");
      end
      $finish;
   end
endmodule

>>> sim.f
rtl/core/ble_pkg.sv
rtl/core/bounded_list_engine.sv
rtl/core/ble_checker.sv
tb/bounded_list_checker.sv
tb/bounded_list_engine_test.sv
